// ===== rtl/pcst_pkg.sv =====
// Shared types and constants for the per-client sequence tracker.
package pcst_pkg;

	// Default client table depth.
	localparam int MAX_CLIENTS_DEF = 6;

	// Request acceptance checks.
	localparam logic [4:0]  REQ_BYTES     = 5'd24;
	localparam logic [31:0] PROTO_VERSION = 32'd7;

	// Reset values of the configuration registers.
	localparam logic [6:0]  DROP_PERCENT_RST  = 7'd0;
	localparam logic [15:0] STALE_SECONDS_RST = 16'd120;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_DROP_PERCENT  = 1'b0,
		REG_STALE_SECONDS = 1'b1
	} cfg_reg_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_MISS,
		ST_DONE
	} state_t;

	// One client table entry as stored in the RAM.
	typedef struct packed {
		logic [31:0] ip;
		logic [15:0] port;
		logic [31:0] max_seq;
		logic [63:0] last_seen;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== rtl/pcst_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module pcst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the read data is registered.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/per_client_sequence_tracker.sv =====
// Top level of the per-client sequence tracker for a time-echo server.
//
// The block takes one request header per transaction on the slave stream and returns one
// result per request on the master stream. A request shorter than 24 bytes, with a version
// other than 7, or whose roll is below drop_percent yields a result with tuser low and all
// data zero. Otherwise the sender is looked up in a client table of MAX_CLIENTS entries held
// in a single-port-read RAM; entries are read one per cycle, in order, until a match is found.
// A discarded request goes from acceptance straight to the done state. A request that
// matches a stored entry is scanned up to that entry and then updated, and a request from
// an unknown sender is scanned past every stored entry (the scan is skipped with an empty
// table) and then added if there is room. The rate is set by the one-entry-per-cycle
// table scan through the RAM read port. The result sits in an output register, so the
// next request is taken while the previous result waits.
module per_client_sequence_tracker #(
	parameter int MAX_CLIENTS = pcst_pkg::MAX_CLIENTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,

	// Configuration writes.
	input  logic         cfg_we,
	input  logic [0:0]   cfg_addr,
	input  logic [15:0]  cfg_wdata,

	// Request stream.
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// byte_length[4:0], seq_number[36:5], version[68:37], client_seconds[132:69],
	// client_nanos[196:133], source_ip[228:197], source_port[244:229],
	// now_seconds[308:245], now_nanos[338:309], drop_roll[345:339], zero pad[351:346]
	input  logic [351:0] s_axis_tdata,

	// Result stream.
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// reply_seq[31:0], reply_client_seconds[95:32], reply_client_nanos[159:96],
	// server_seconds[223:160], server_nanos[253:224], dest_ip[285:254],
	// dest_port[301:286], out_of_order[302], recorded_max_seq[334:303], zero pad[335]
	output logic [335:0] m_axis_tdata,
	// send_reply
	output logic         m_axis_tuser
);

	localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
	localparam int CNT_W = $clog2(MAX_CLIENTS + 1);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CLIENTS);

	// Unpacked request fields.
	logic [4:0]  in_byte_length;
	logic [31:0] in_seq_number;
	logic [31:0] in_version;
	logic [63:0] in_client_seconds;
	logic [63:0] in_client_nanos;
	logic [31:0] in_source_ip;
	logic [15:0] in_source_port;
	logic [63:0] in_now_seconds;
	logic [29:0] in_now_nanos;
	logic [6:0]  in_drop_roll;

	assign in_byte_length    = s_axis_tdata[4:0];
	assign in_seq_number     = s_axis_tdata[36:5];
	assign in_version        = s_axis_tdata[68:37];
	assign in_client_seconds = s_axis_tdata[132:69];
	assign in_client_nanos   = s_axis_tdata[196:133];
	assign in_source_ip      = s_axis_tdata[228:197];
	assign in_source_port    = s_axis_tdata[244:229];
	assign in_now_seconds    = s_axis_tdata[308:245];
	assign in_now_nanos      = s_axis_tdata[338:309];
	assign in_drop_roll      = s_axis_tdata[345:339];

	// Control and configuration registers.
	pcst_pkg::state_t state_q, state_d;
	logic [6:0]       drop_percent_q;
	logic [15:0]      stale_seconds_q;
	logic [CNT_W-1:0] entry_count_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic             rd_vld_s1;
	logic             out_valid_q;

	// Payload registers of the request in flight.
	logic [31:0]      seq_q;
	logic [63:0]      csec_q;
	logic [63:0]      cnsec_q;
	logic [31:0]      ip_q;
	logic [15:0]      port_q;
	logic [63:0]      now_q;
	logic [29:0]      nnsec_q;
	logic             send_q;
	logic             ooo_q;
	logic [31:0]      recmax_q;
	logic [IDX_W-1:0] rd_idx_s1;
	logic             rd_last_s1;
	logic [IDX_W-1:0] hit_idx_q;
	logic             later_q;
	logic [63:0]      gap_q;
	logic             seq_lt_q;
	logic             seq_gt_q;
	logic [31:0]      cur_max_q;

	// Output register.
	logic [335:0]     out_data_q;
	logic             out_user_q;

	// Handshake and RAM controls.
	logic             accept;
	logic             pass;
	logic             out_free;
	logic             issue;
	logic             match;
	logic             load_out;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	pcst_pkg::entry_t ram_wentry;
	logic [pcst_pkg::ENTRY_W-1:0] ram_rdata;
	pcst_pkg::entry_t rd_entry;
	logic             stale;
	logic [31:0]      new_max;
	logic             upd_ooo;
	logic             room;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign pass     = (in_byte_length >= pcst_pkg::REQ_BYTES) &&
	                  (in_version == pcst_pkg::PROTO_VERSION) &&
	                  (in_drop_roll >= drop_percent_q);
	assign rd_entry = pcst_pkg::entry_t'(ram_rdata);
	assign match    = rd_vld_s1 && (rd_entry.ip == ip_q) && (rd_entry.port == port_q);
	assign room     = entry_count_q < MAX_CNT;

	// Sequence update for a known client, from values captured at the hit.
	assign stale   = later_q && (gap_q > {48'd0, stale_seconds_q});
	assign upd_ooo = !stale && seq_lt_q;
	assign new_max = (stale || seq_gt_q) ? seq_q : cur_max_q;

	// Client table storage.
	pcst_ram #(
		.WIDTH(pcst_pkg::ENTRY_W),
		.DEPTH(MAX_CLIENTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wentry),
		.re   (issue),
		.raddr(rd_idx_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pcst_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					if (!pass) begin
						state_d = pcst_pkg::ST_DONE;
					end else if (entry_count_q == '0) begin
						state_d = pcst_pkg::ST_MISS;
					end else begin
						state_d = pcst_pkg::ST_SCAN;
					end
				end
			end
			pcst_pkg::ST_SCAN: begin
				if (match) begin
					state_d = pcst_pkg::ST_UPDATE;
				end else if (rd_vld_s1 && rd_last_s1) begin
					state_d = pcst_pkg::ST_MISS;
				end
			end
			pcst_pkg::ST_UPDATE: state_d = pcst_pkg::ST_DONE;
			pcst_pkg::ST_MISS:   state_d = pcst_pkg::ST_DONE;
			pcst_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = pcst_pkg::ST_IDLE;
				end
			end
			default: state_d = pcst_pkg::ST_IDLE;
		endcase
	end

	// Output logic of the controller.
	always_comb begin
		s_axis_tready = 1'b0;
		issue         = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = hit_idx_q;
		ram_wentry    = '{ip: ip_q, port: port_q, max_seq: new_max, last_seen: now_q};
		load_out      = 1'b0;
		unique case (state_q)
			pcst_pkg::ST_IDLE: s_axis_tready = 1'b1;
			pcst_pkg::ST_SCAN: issue = (rd_idx_q < entry_count_q) && !match;
			pcst_pkg::ST_UPDATE: ram_we = 1'b1;
			pcst_pkg::ST_MISS: begin
				ram_we     = room;
				ram_waddr  = entry_count_q[IDX_W-1:0];
				ram_wentry = '{ip: ip_q, port: port_q, max_seq: seq_q, last_seen: now_q};
			end
			pcst_pkg::ST_DONE: load_out = out_free;
			default: ;
		endcase
	end

	// Control state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= pcst_pkg::ST_IDLE;
			drop_percent_q  <= pcst_pkg::DROP_PERCENT_RST;
			stale_seconds_q <= pcst_pkg::STALE_SECONDS_RST;
			entry_count_q   <= '0;
			rd_idx_q        <= '0;
			rd_vld_s1       <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (cfg_we) begin
				unique case (pcst_pkg::cfg_reg_t'(cfg_addr))
					pcst_pkg::REG_DROP_PERCENT:  drop_percent_q  <= cfg_wdata[6:0];
					pcst_pkg::REG_STALE_SECONDS: stale_seconds_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (accept) begin
				rd_idx_q <= '0;
			end else if (issue) begin
				rd_idx_q <= CNT_W'(rd_idx_q + 1'b1);
			end
			if (state_q == pcst_pkg::ST_MISS && room) begin
				entry_count_q <= CNT_W'(entry_count_q + 1'b1);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request payload, scan results and the result under construction.
	always_ff @(posedge clk) begin
		if (accept) begin
			seq_q    <= in_seq_number;
			csec_q   <= in_client_seconds;
			cnsec_q  <= in_client_nanos;
			ip_q     <= in_source_ip;
			port_q   <= in_source_port;
			now_q    <= in_now_seconds;
			nnsec_q  <= in_now_nanos;
			send_q   <= pass;
			ooo_q    <= 1'b0;
			recmax_q <= '0;
		end
		if (issue) begin
			rd_idx_s1  <= rd_idx_q[IDX_W-1:0];
			rd_last_s1 <= (CNT_W'(rd_idx_q + 1'b1) == entry_count_q);
		end
		if (match) begin
			hit_idx_q <= rd_idx_s1;
			later_q   <= now_q > rd_entry.last_seen;
			gap_q     <= now_q - rd_entry.last_seen;
			seq_lt_q  <= seq_q < rd_entry.max_seq;
			seq_gt_q  <= seq_q > rd_entry.max_seq;
			cur_max_q <= rd_entry.max_seq;
		end
		if (state_q == pcst_pkg::ST_UPDATE) begin
			ooo_q    <= upd_ooo;
			recmax_q <= upd_ooo ? cur_max_q : '0;
		end
		if (load_out) begin
			out_user_q <= send_q;
			if (send_q) begin
				out_data_q <= {1'b0, recmax_q, ooo_q, port_q, ip_q, nnsec_q, now_q,
				               cnsec_q, csec_q, seq_q};
			end else begin
				out_data_q <= '0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	// The table never holds more clients than it has room for.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= MAX_CNT)
		else $error("client count exceeds table depth");

	// The table is written only while updating or adding a client.
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == pcst_pkg::ST_UPDATE || state_q == pcst_pkg::ST_MISS))
		else $error("table written outside an update");

	// An update always targets a stored client.
	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pcst_pkg::ST_UPDATE) |-> (CNT_W'(hit_idx_q) < entry_count_q))
		else $error("update of an unused table entry");

	// Adding a client with room left grows the table by one.
	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pcst_pkg::ST_MISS && room) |=>
		(entry_count_q == CNT_W'($past(entry_count_q) + 1'b1)))
		else $error("new client not counted");

	// Reads are issued only during the table scan and only below the fill count.
	a_read_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (state_q == pcst_pkg::ST_SCAN && rd_idx_q < entry_count_q))
		else $error("table read outside the scan");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the per-client sequence tracker with a built-in predictor.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH   = pcst_pkg::MAX_CLIENTS_DEF;
	localparam int SETTLE_CYCLES = pcst_pkg::MAX_CLIENTS_DEF + 8;
	localparam int MAX_GAP       = 13;
	localparam int PHASE_ITEMS   = 235;
	localparam int HOLD_CYCLES   = 400;
	localparam int POOL_SIZE     = 8;

	// Request header as packed on the slave stream, highest field first.
	typedef struct packed {
		logic [5:0]  pad;
		logic [6:0]  roll;
		logic [29:0] now_nanos;
		logic [63:0] now_sec;
		logic [15:0] port;
		logic [31:0] ip;
		logic [63:0] cli_nanos;
		logic [63:0] cli_sec;
		logic [31:0] version;
		logic [31:0] seq;
		logic [4:0]  length;
	} request_t;

	// Reply body as packed on the master stream, highest field first.
	typedef struct packed {
		logic        pad;
		logic [31:0] recorded_max;
		logic        out_of_order;
		logic [15:0] dest_port;
		logic [31:0] dest_ip;
		logic [29:0] srv_nanos;
		logic [63:0] srv_sec;
		logic [63:0] cli_nanos;
		logic [63:0] cli_sec;
		logic [31:0] seq;
	} reply_t;

	typedef struct packed {
		logic   send;
		reply_t body;
	} expected_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_we = 1'b0;
	logic [0:0]   cfg_addr = '0;
	logic [15:0]  cfg_wdata = '0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [351:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [335:0] m_axis_tdata;
	logic         m_axis_tuser;

	per_client_sequence_tracker uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	// Predictor copy of the client table and the configuration.
	logic [31:0] tbl_ip   [TABLE_DEPTH];
	logic [15:0] tbl_port [TABLE_DEPTH];
	logic [31:0] tbl_max  [TABLE_DEPTH];
	logic [63:0] tbl_seen [TABLE_DEPTH];
	int          client_count = 0;
	logic [6:0]  drop_pct = pcst_pkg::DROP_PERCENT_RST;
	logic [15:0] stale_secs = pcst_pkg::STALE_SECONDS_RST;

	request_t  pending_requests[$];
	expected_t pending_replies[$];

	int pushed = 0;
	int accepted = 0;
	int checked = 0;
	int errors = 0;
	int sent_count = 0;
	int discard_count = 0;
	int ooo_count = 0;

	bit req_taken = 1'b0;
	bit reply_taken = 1'b0;
	bit no_idle = 1'b0;
	int hold_request = 0;
	int hold_left = 0;
	int send_gap = 0;
	int stall_left = 0;

	// Stimulus-side view of the client pool.
	logic [31:0] pool_ip   [POOL_SIZE];
	logic [15:0] pool_port [POOL_SIZE];
	logic [31:0] pool_seq  [POOL_SIZE];
	logic [63:0] pool_time [POOL_SIZE];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	// Computes the reply for one accepted request and updates the client table.
	function automatic expected_t track_request(request_t r);
		expected_t e;
		int hit;
		e = '0;
		hit = -1;
		if (r.length < pcst_pkg::REQ_BYTES || r.version != pcst_pkg::PROTO_VERSION ||
		    r.roll < drop_pct)
			return e;
		for (int k = 0; k < client_count; k++)
			if (hit < 0 && tbl_ip[k] == r.ip && tbl_port[k] == r.port)
				hit = k;
		if (hit < 0) begin
			// Unknown sender: take a free slot, or leave the full table alone.
			if (client_count < TABLE_DEPTH) begin
				tbl_ip[client_count] = r.ip;
				tbl_port[client_count] = r.port;
				tbl_max[client_count] = r.seq;
				tbl_seen[client_count] = r.now_sec;
				client_count++;
			end
		end else begin
			// A clock that moved backwards never counts as stale.
			if (r.now_sec > tbl_seen[hit] && r.now_sec - tbl_seen[hit] > 64'(stale_secs)) begin
				tbl_max[hit] = r.seq;
			end else if (r.seq < tbl_max[hit]) begin
				e.body.out_of_order = 1'b1;
				e.body.recorded_max = tbl_max[hit];
			end else if (r.seq > tbl_max[hit]) begin
				tbl_max[hit] = r.seq;
			end
			tbl_seen[hit] = r.now_sec;
		end
		e.send = 1'b1;
		e.body.seq = r.seq;
		e.body.cli_sec = r.cli_sec;
		e.body.cli_nanos = r.cli_nanos;
		e.body.srv_sec = r.now_sec;
		e.body.srv_nanos = r.now_nanos;
		e.body.dest_ip = r.ip;
		e.body.dest_port = r.port;
		return e;
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= 10)
				$display("mismatch on result %0d, %s: expected %h, got %h",
					checked, name, want, got);
		end
	endfunction

	// Request driver: holds an offered transaction until taken, then waits its gap.
	always @(negedge clk) begin
		if (!arst_n) begin
		end else if (s_axis_tvalid && !req_taken) begin
		end else if (send_gap > 0) begin
			send_gap--;
			s_axis_tvalid <= 1'b0;
		end else if (pending_requests.size() > 0) begin
			s_axis_tdata <= pending_requests.pop_front();
			s_axis_tvalid <= 1'b1;
			send_gap = draw_gap();
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// Result receiver: random stalls per transaction and one long hold-off on request.
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (reply_taken)
			stall_left = draw_gap();
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Monitor: predicts on each accepted request and checks each accepted result.
	always @(posedge clk) begin
		expected_t want;
		reply_t got;
		req_taken = arst_n && s_axis_tvalid && s_axis_tready;
		reply_taken = arst_n && m_axis_tvalid && m_axis_tready;
		if (req_taken) begin
			pending_replies.push_back(track_request(request_t'(s_axis_tdata)));
			accepted++;
		end
		if (reply_taken) begin
			if (pending_replies.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: tuser %b, tdata %h", m_axis_tuser, m_axis_tdata);
			end else begin
				want = pending_replies.pop_front();
				got = m_axis_tdata;
				check_field("send_reply", 64'(want.send), 64'(m_axis_tuser));
				check_field("reply_seq", 64'(want.body.seq), 64'(got.seq));
				check_field("reply_client_seconds", want.body.cli_sec, got.cli_sec);
				check_field("reply_client_nanos", want.body.cli_nanos, got.cli_nanos);
				check_field("server_seconds", want.body.srv_sec, got.srv_sec);
				check_field("server_nanos", 64'(want.body.srv_nanos), 64'(got.srv_nanos));
				check_field("dest_ip", 64'(want.body.dest_ip), 64'(got.dest_ip));
				check_field("dest_port", 64'(want.body.dest_port), 64'(got.dest_port));
				check_field("out_of_order", 64'(want.body.out_of_order),
					64'(got.out_of_order));
				check_field("recorded_max_seq", 64'(want.body.recorded_max),
					64'(got.recorded_max));
				if (!want.send)
					discard_count++;
				else
					sent_count++;
				if (want.body.out_of_order)
					ooo_count++;
			end
			checked++;
		end
	end

	task automatic queue_request(request_t r);
		pending_requests.push_back(r);
		pushed++;
	endtask

	// Well-formed request from a pool client with random echo content.
	function automatic request_t good_request(int who, logic [31:0] seq, logic [63:0] now);
		request_t r;
		r = '0;
		r.length = pcst_pkg::REQ_BYTES;
		r.version = pcst_pkg::PROTO_VERSION;
		r.seq = seq;
		r.ip = pool_ip[who];
		r.port = pool_port[who];
		r.now_sec = now;
		r.now_nanos = 30'($urandom);
		r.cli_sec = {$urandom, $urandom};
		r.cli_nanos = {$urandom, $urandom};
		r.roll = 7'($urandom_range(0, 127));
		return r;
	endfunction

	// One random request: mostly well-formed traffic from the pool, some noise and
	// some near-miss headers.
	task automatic queue_random_request();
		request_t r;
		int kind;
		int who;
		int pick;
		logic [31:0] seq;
		logic [63:0] now;
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			r = good_request(0, $urandom, {$urandom, $urandom});
			r.length = 5'($urandom);
			r.version = $urandom_range(0, 1) ? pcst_pkg::PROTO_VERSION : 32'($urandom);
			r.ip = $urandom;
			r.port = 16'($urandom);
		end else begin
			who = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
			pick = $urandom_range(0, 99);
			if (pick < 78)
				now = pool_time[who] + 64'($urandom_range(0, 3));
			else if (pick < 86)
				now = pool_time[who] + 64'(stale_secs) + 64'($urandom_range(1, 40));
			else if (pick < 94)
				now = pool_time[who] + 64'(stale_secs);
			else
				now = pool_time[who] - 64'($urandom_range(1, 200));
			pick = $urandom_range(0, 99);
			if (pick < 65)
				seq = pool_seq[who] + 32'($urandom_range(1, 3));
			else if (pick < 80)
				seq = pool_seq[who] - 32'($urandom_range(1, 20));
			else if (pick < 88)
				seq = pool_seq[who];
			else
				seq = $urandom;
			r = good_request(who, seq, now);
			if ($urandom_range(0, 3) == 0)
				r.length = 5'($urandom_range(24, 31));
			if (kind >= 90) begin
				if ($urandom_range(0, 1))
					r.length = 5'($urandom_range(0, 23));
				else
					r.version = pcst_pkg::PROTO_VERSION ^ (32'd1 << $urandom_range(0, 31));
			end else begin
				pool_seq[who] = seq;
				pool_time[who] = now;
			end
		end
		queue_request(r);
	endtask

	task automatic write_register(pcst_pkg::cfg_reg_t idx, logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		case (idx)
			pcst_pkg::REG_DROP_PERCENT:  drop_pct = value[6:0];
			pcst_pkg::REG_STALE_SECONDS: stale_secs = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits until every queued request has been taken and answered, then lets the
	// block settle.
	task automatic wait_drained();
		while (accepted != pushed || checked != pushed)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		request_t r;
		logic [63:0] t;
		logic [15:0] phase_drop [6];
		logic [15:0] phase_stale [6];

		// Client pool: distinct low bits; B shares A's address, C shares A's port.
		for (int k = 0; k < POOL_SIZE; k++) begin
			pool_ip[k] = $urandom;
			pool_ip[k][2:0] = 3'(k);
			pool_port[k] = {13'($urandom), 3'(k)};
			pool_seq[k] = $urandom_range(0, 1000);
		end
		pool_ip[1] = pool_ip[0];
		pool_port[2] = pool_port[0];
		t = 64'h0000_0000_6500_0000;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at reset settings: length and version checks, new entries,
		// ordering, stale boundary, backwards clock, full table and field extremes.
		r = good_request(0, 32'd100, t);
		r.length = 5'd23;
		queue_request(r);
		r.length = 5'd0;
		queue_request(r);
		r.length = 5'd31;
		queue_request(r);
		r = good_request(0, 32'd50, t);
		r.version = 32'd8;
		queue_request(r);
		r.version = 32'hFFFF_FFFF;
		queue_request(r);
		queue_request(good_request(0, 32'd99, t + 1));
		queue_request(good_request(0, 32'd100, t + 2));
		queue_request(good_request(0, 32'hFFFF_FFFF, t + 3));
		queue_request(good_request(1, 32'd7, t));
		queue_request(good_request(2, 32'd8, t));
		queue_request(good_request(0, 32'd5, t + 3 + 120));
		queue_request(good_request(0, 32'd5, t + 3 + 120 + 121));
		queue_request(good_request(0, 32'd3, t + 100));
		queue_request(good_request(3, 32'd0, t));
		queue_request(good_request(4, 32'd9, t));
		queue_request(good_request(5, 32'd10, t));
		queue_request(good_request(6, 32'd1, t));
		queue_request(good_request(6, 32'd0, t));
		r = good_request(4, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		r.now_nanos = 30'h3FFF_FFFF;
		r.cli_sec = '1;
		r.cli_nanos = '1;
		queue_request(r);
		queue_request(good_request(4, 32'd0, 64'd0));
		wait_drained();

		// Roll just below and at the drop threshold, then the out-of-range percentage.
		write_register(pcst_pkg::REG_DROP_PERCENT, 16'd50);
		r = good_request(1, 32'd20, t + 5);
		r.roll = 7'd49;
		queue_request(r);
		r.roll = 7'd50;
		queue_request(r);
		wait_drained();
		write_register(pcst_pkg::REG_DROP_PERCENT, 16'd127);
		r = good_request(2, 32'd30, t + 5);
		r.roll = 7'd126;
		queue_request(r);
		r.roll = 7'd127;
		queue_request(r);
		wait_drained();

		for (int k = 0; k < POOL_SIZE; k++)
			pool_time[k] = t + 64'd1000;

		// Random phases over several settings, extremes included.
		phase_drop[0] = 16'd0;    phase_stale[0] = 16'd0;
		phase_drop[1] = 16'hA51E; phase_stale[1] = 16'd120;
		phase_drop[2] = 16'd100;  phase_stale[2] = 16'hFFFF;
		phase_drop[3] = 16'd127;  phase_stale[3] = 16'd5;
		phase_drop[4] = 16'd0;    phase_stale[4] = 16'd10;
		phase_drop[5] = 16'd15;   phase_stale[5] = 16'd300;
		for (int p = 0; p < 6; p++) begin
			write_register(pcst_pkg::REG_DROP_PERCENT, phase_drop[p]);
			write_register(pcst_pkg::REG_STALE_SECONDS, phase_stale[p]);
			no_idle = (p == 1 || p == 3);
			if (p == 4)
				hold_request = HOLD_CYCLES;
			for (int n = 0; n < PHASE_ITEMS; n++)
				queue_random_request();
			wait_drained();
		end

		repeat (20) @(posedge clk);
		if (pending_replies.size() != 0) begin
			errors++;
			$display("%0d expected results never arrived", pending_replies.size());
		end
		$display("Covered %0d requests over 9 register settings: %0d replies, %0d discarded,",
			accepted, sent_count, discard_count);
		$display("%0d flagged out of order, %0d clients in the table, %0d failures.",
			ooo_count, client_count, errors);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#6_000_000;
		$display("timeout: %0d of %0d requests answered", checked, pushed);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== per_client_sequence_tracker.f =====
rtl/pcst_pkg.sv
rtl/pcst_ram.sv
rtl/per_client_sequence_tracker.sv
test/tb.sv
